/* sv/sxlr_pkg.sv */
// ============================================================================
// sxlr_pkg
// Shared types and constants for the synced XOR frame receiver.
// ============================================================================
package sxlr_pkg;

    // configuration register widths and port shape
    localparam int CFG_LED_W   = 9;
    localparam int CFG_TICK_W  = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_IDX_W   = 2;

    // payload field widths
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 8;
    localparam int SLOT_W      = 2;
    localparam int CNT_W       = 32;

    // stream widths
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 88;
    localparam int M_TUSER_W   = 2;

    localparam int MAX_LEDS_DEF = 256;
    localparam int QUEUE_DEPTH  = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STRIP_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

    // register reset values
    localparam logic [CFG_LED_W-1:0]  STRIP_A_RST = 9'd128;
    localparam logic [CFG_LED_W-1:0]  TOTAL_RST   = 9'd256;
    localparam logic [CFG_TICK_W-1:0] TIMEOUT_RST = 16'd50;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFF;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hAA;

    localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd2;

    typedef enum logic [0:0] {
        KIND_BYTE = 1'b0,
        KIND_TICK = 1'b1
    } item_kind_t;

    typedef enum logic [1:0] {
        EV_STAGED  = 2'd0,
        EV_GOOD    = 2'd1,
        EV_BAD     = 2'd2,
        EV_TIMEOUT = 2'd3
    } event_kind_t;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SECOND  = 2'd1,
        PH_PAYLOAD = 2'd2
    } phase_t;

    // one classified event as it travels through the queue
    typedef struct packed {
        event_kind_t         kind;
        logic                strip_sel;
        logic [IDX_W-1:0]    led_index;
        logic [SLOT_W-1:0]   color_slot;
        logic [BYTE_W-1:0]   byte_value;
    } evt_t;

endpackage

/* sv/sxlr_front.sv */
// ============================================================================
// sxlr_front
// Sync hunt, payload tracking, checksum and timeout; emits classified events.
// ============================================================================
module sxlr_front
    import sxlr_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   item_accept,
    input  logic                   item_tick,
    input  logic [BYTE_W-1:0]      item_byte,
    output logic                   push,
    output evt_t                   push_evt
);

    localparam int LED_NEED_W = $clog2(MAX_LEDS + 1);
    localparam int PIX_W = (LED_NEED_W > CFG_LED_W) ? LED_NEED_W : CFG_LED_W;
    localparam logic [PIX_W-1:0] MAX_LEDS_P = PIX_W'(MAX_LEDS);
    localparam logic [CFG_TICK_W-1:0] TICK_SAT = '1;

    logic [CFG_LED_W-1:0]  strip_a_reg;
    logic [CFG_LED_W-1:0]  total_reg;
    logic [CFG_TICK_W-1:0] timeout_reg;

    phase_t                phase_reg, phase_next;
    logic [PIX_W-1:0]      pix_reg, pix_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [BYTE_W-1:0]     xor_reg, xor_next;
    logic [CFG_TICK_W-1:0] ticks_reg, ticks_next;

    logic [PIX_W-1:0]      total_ext;
    logic [PIX_W-1:0]      leds_eff;
    logic [PIX_W-1:0]      strip_a_ext;
    logic [PIX_W-1:0]      pix_off;
    logic [CFG_TICK_W-1:0] ticks_inc;
    logic                  in_payload;
    logic                  timed_out;
    logic                  second_strip;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strip_a_reg <= STRIP_A_RST;
            total_reg   <= TOTAL_RST;
            timeout_reg <= TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STRIP_A: strip_a_reg <= cfg_data[CFG_LED_W-1:0];
                REG_TOTAL:   total_reg   <= cfg_data[CFG_LED_W-1:0];
                REG_TIMEOUT: timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign total_ext    = PIX_W'(total_reg);
    assign leds_eff     = (total_ext > MAX_LEDS_P) ? MAX_LEDS_P : total_ext;
    assign in_payload   = (pix_reg < leds_eff);
    assign strip_a_ext  = PIX_W'(strip_a_reg);
    assign second_strip = (pix_reg >= strip_a_ext);
    assign pix_off      = pix_reg - strip_a_ext;
    assign ticks_inc    = (ticks_reg == TICK_SAT) ? ticks_reg : ticks_reg + 1'b1;
    assign timed_out    = (ticks_inc > timeout_reg);

    // next state
    always_comb begin
        phase_next = phase_reg;
        if (item_accept) begin
            if (item_tick) begin
                if (phase_reg == PH_PAYLOAD && timed_out) begin
                    phase_next = PH_HUNT;
                end
            end else begin
                unique case (phase_reg)
                    PH_SECOND: begin
                        if (item_byte == SYNC_SECOND) begin
                            phase_next = PH_PAYLOAD;
                        end else if (item_byte != SYNC_FIRST) begin
                            phase_next = PH_HUNT;
                        end
                    end
                    PH_PAYLOAD: begin
                        if (!in_payload) begin
                            phase_next = PH_HUNT;
                        end
                    end
                    default: begin
                        phase_next = (item_byte == SYNC_FIRST) ? PH_SECOND : PH_HUNT;
                    end
                endcase
            end
        end
    end

    // frame datapath
    always_comb begin
        pix_next   = pix_reg;
        slot_next  = slot_reg;
        xor_next   = xor_reg;
        ticks_next = ticks_reg;
        if (item_accept) begin
            if (item_tick) begin
                if (phase_reg == PH_PAYLOAD) begin
                    ticks_next = ticks_inc;
                end
            end else if (phase_reg == PH_SECOND && item_byte == SYNC_SECOND) begin
                pix_next   = '0;
                slot_next  = '0;
                xor_next   = '0;
                ticks_next = '0;
            end else if (phase_reg == PH_PAYLOAD && in_payload) begin
                xor_next = xor_reg ^ item_byte;
                if (slot_reg == SLOT_LAST) begin
                    slot_next = '0;
                    pix_next  = pix_reg + 1'b1;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
        end
    end

    // emitted event
    always_comb begin
        push     = 1'b0;
        push_evt = '0;
        if (item_accept && phase_reg == PH_PAYLOAD) begin
            if (item_tick) begin
                if (timed_out) begin
                    push          = 1'b1;
                    push_evt.kind = EV_TIMEOUT;
                end
            end else if (in_payload) begin
                push                = 1'b1;
                push_evt.kind       = EV_STAGED;
                push_evt.strip_sel  = second_strip;
                push_evt.led_index  = second_strip ? pix_off[IDX_W-1:0]
                                                   : pix_reg[IDX_W-1:0];
                push_evt.color_slot = slot_reg;
                push_evt.byte_value = item_byte;
            end else begin
                push          = 1'b1;
                push_evt.kind = (xor_reg == item_byte) ? EV_GOOD : EV_BAD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pix_reg   <= '0;
            slot_reg  <= '0;
            xor_reg   <= '0;
            ticks_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pix_reg   <= pix_next;
            slot_reg  <= slot_next;
            xor_reg   <= xor_next;
            ticks_reg <= ticks_next;
        end
    end

    // color slot never reaches the unused code
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg != 2'd3)
        else $error("slot counter out of range");

    // pixel count never runs past the largest frame
    a_pix_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pix_reg <= MAX_LEDS_P)
        else $error("pixel counter overran frame");

    // a sync pair always opens a clean frame
    a_sync_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_accept && !item_tick && phase_reg == PH_SECOND
         && item_byte == SYNC_SECOND)
        |=> (phase_reg == PH_PAYLOAD && pix_reg == '0 && xor_reg == '0
             && ticks_reg == '0))
        else $error("frame state not cleared on sync");

endmodule

/* sv/sxlr_queue.sv */
// ============================================================================
// sxlr_queue
// Short event queue between the classifier and the output stage.
// ============================================================================
module sxlr_queue
    import sxlr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  evt_t  push_evt,
    input  logic  pop,
    output logic  full,
    output logic  q_valid,
    output evt_t  head
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(QUEUE_DEPTH);

    evt_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_pop;

    assign full    = (count_reg == DEPTH_C);
    assign q_valid = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_evt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= DEPTH_C)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != DEPTH_C) |-> (PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0]))
        else $error("queue pointers disagree with count");

endmodule

/* sv/sxlr_back.sv */
// ============================================================================
// sxlr_back
// Output stage: frame statistics and the registered result channel.
// ============================================================================
module sxlr_back
    import sxlr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    input  evt_t                  head,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata: strip_sel[0], led_index[8:1], color_slot[10:9], byte_value[18:11],
    //          good_frames[50:19], bad_frames[82:51], zero[87:83]
    output logic [M_TDATA_W-1:0]  m_tdata,
    // m_tuser: event_kind[1:0]
    output logic [M_TUSER_W-1:0]  m_tuser
);

    localparam int PAD_W = M_TDATA_W - (1 + IDX_W + SLOT_W + BYTE_W + 2 * CNT_W);
    localparam logic [CNT_W-1:0] CNT_SAT = '1;

    logic             valid_reg;
    evt_t             evt_reg;
    logic [CNT_W-1:0] good_reg, good_next;
    logic [CNT_W-1:0] bad_reg, bad_next;

    assign pop = q_valid && (!valid_reg || m_tready);

    always_comb begin
        good_next = good_reg;
        bad_next  = bad_reg;
        case (head.kind) inside
            EV_GOOD: begin
                if (good_reg != CNT_SAT) good_next = good_reg + 1'b1;
            end
            EV_BAD, EV_TIMEOUT: begin
                if (bad_reg != CNT_SAT) bad_next = bad_reg + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            evt_reg <= head;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            good_reg  <= '0;
            bad_reg   <= '0;
        end else begin
            if (pop) begin
                valid_reg <= 1'b1;
                good_reg  <= good_next;
                bad_reg   <= bad_next;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = evt_reg.kind;
    assign m_tdata  = {{PAD_W{1'b0}}, bad_reg, good_reg, evt_reg.byte_value,
                       evt_reg.color_slot, evt_reg.led_index, evt_reg.strip_sel};

    a_good_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && evt_reg.kind == EV_GOOD) |-> (good_reg != '0))
        else $error("good event without good count");

    a_bad_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && (evt_reg.kind == EV_BAD || evt_reg.kind == EV_TIMEOUT))
        |-> (bad_reg != '0))
        else $error("bad event without bad count");

    a_frame_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && evt_reg.kind != EV_STAGED)
        |-> (evt_reg.byte_value == '0 && evt_reg.led_index == '0
             && evt_reg.color_slot == '0 && !evt_reg.strip_sel))
        else $error("frame event carries payload fields");

endmodule

/* sv/synced_xor_led_frame_receiver.sv */
// ============================================================================
// synced_xor_led_frame_receiver
// Serial frame receiver: 0xFF 0xAA sync, payload staging, XOR check, timeout.
// ============================================================================
// Usage:
//   Input stream s_*: one item per handshake. s_tuser[0] selects the kind
//   (0 = serial byte in s_tdata, 1 = one millisecond tick). Bytes drive the
//   sync hunt, payload staging and checksum; ticks age an open frame.
//   Output stream m_*: at most one result item per input item. m_tuser holds
//   the event kind (staged byte, frame good, checksum bad, timeout); m_tdata
//   carries strip, index within strip, color slot, byte and both counters.
//   Config port: cfg_wr_en writes cfg_data into register cfg_index
//   (0 strip A size, 1 LEDs per frame, 2 timeout in ticks); write while idle.
// Throughput: one item per clock while the event queue has a free slot.
// Path: an accepted item is classified into the event queue, then popped
//   into the output register that drives m_*.
// Stalls: a four-entry queue plus the output register decouple the sides;
//   s_tready drops only while the queue is full, as when m_tready is held low.
// Reset (aresetn low, synchronous): registers return to 128/256/50, the
//   receiver goes back to sync hunt, counters clear and the queue empties.
// ============================================================================
module synced_xor_led_frame_receiver
    import sxlr_pkg::*;
#(
    parameter int MAX_LEDS = MAX_LEDS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration writes
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata: rx_byte[7:0]
    input  logic [S_TDATA_W-1:0]   s_tdata,
    // s_tuser: func[0]
    input  logic [S_TUSER_W-1:0]   s_tuser,
    // result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: strip_sel[0], led_index[8:1], color_slot[10:9], byte_value[18:11],
    //          good_frames[50:19], bad_frames[82:51], zero[87:83]
    output logic [M_TDATA_W-1:0]   m_tdata,
    // m_tuser: event_kind[1:0]
    output logic [M_TUSER_W-1:0]   m_tuser
);

    logic item_accept;
    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    evt_t push_evt;
    evt_t head;

    // an item is taken only while the queue has a free slot for its event
    assign s_tready    = !q_full;
    assign item_accept = s_tvalid && s_tready;

    sxlr_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .item_accept (item_accept),
        .item_tick   (s_tuser[0] == KIND_TICK),
        .item_byte   (s_tdata[BYTE_W-1:0]),
        .push        (push),
        .push_evt    (push_evt)
    );

    sxlr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_evt (push_evt),
        .pop      (pop),
        .full     (q_full),
        .q_valid  (q_valid),
        .head     (head)
    );

    sxlr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
